// ----- rtl/core/dotq_pkg.sv -----
// Shared types, operation codes and constants for the deadline-ordered timer queue.
package dotq_pkg;

    // Field widths fixed by the stream format
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned TAG_W    = 32;
    localparam int unsigned DELAY_W  = 32;
    localparam int unsigned PERIOD_W = 32;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned S_DATA_W = 96;
    localparam int unsigned M_DATA_W = 72;

    // Defaults for the top-level parameters
    localparam int unsigned DEF_TABLE_DEPTH = 16;
    localparam int unsigned DEF_TIME_WIDTH  = 48;

    // Most jobs fired by one tick
    localparam int unsigned MAX_FIRE = 16;

    // Function codes on the input stream
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEL  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADV  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DONE = 3'd4;

    // Internal operation codes after classification
    localparam logic [2:0] OP_ADD  = 3'd0;
    localparam logic [2:0] OP_DEL  = 3'd1;
    localparam logic [2:0] OP_ADV  = 3'd2;
    localparam logic [2:0] OP_TICK = 3'd3;
    localparam logic [2:0] OP_DONE = 3'd4;
    localparam logic [2:0] OP_NOP  = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd2;

    // Classified command passed from front to back
    typedef struct packed {
        logic [2:0]          op;
        logic [TAG_W-1:0]    tag;
        logic [DELAY_W-1:0]  dly;
        logic [PERIOD_W-1:0] per;
    } t_cmd;

endpackage

// ----- rtl/core/dotq_front.sv -----
// Front end: accepts input words, classifies the function and queues commands.
module dotq_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dotq_pkg::S_DATA_W-1:0]      i_s_tdata,
    input  logic [dotq_pkg::FUNC_W-1:0]        i_s_tuser,
    output logic                               o_cmd_valid,
    output dotq_pkg::t_cmd                     o_cmd,
    input  logic                               i_cmd_pop
);

    dotq_pkg::t_cmd r_q [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    logic           s_push;
    dotq_pkg::t_cmd s_new;
    logic [2:0]     s_op;

    // Classify the function code
    always_comb begin
        case (i_s_tuser)
            dotq_pkg::FUNC_ADD:  s_op = dotq_pkg::OP_ADD;
            dotq_pkg::FUNC_DEL:  s_op = dotq_pkg::OP_DEL;
            dotq_pkg::FUNC_ADV:  s_op = dotq_pkg::OP_ADV;
            dotq_pkg::FUNC_TICK: s_op = dotq_pkg::OP_TICK;
            dotq_pkg::FUNC_DONE: s_op = dotq_pkg::OP_DONE;
            default:             s_op = dotq_pkg::OP_NOP;
        endcase
    end

    assign s_new.op  = s_op;
    assign s_new.tag = i_s_tdata[31:0];
    assign s_new.dly = i_s_tdata[63:32];
    assign s_new.per = i_s_tdata[95:64];

    assign o_s_tready  = (r_cnt != 2'd2);
    assign s_push      = i_s_tvalid && o_s_tready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (s_push && !i_cmd_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!s_push && i_cmd_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Hold the two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (s_push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q[r_wr] <= s_new;
        end
    end

endmodule

// ----- rtl/core/dotq_engine.sv -----
// Back end: walks the sorted timer list and free list, produces result words.
module dotq_engine #(
    parameter int unsigned TABLE_DEPTH = dotq_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned TIME_WIDTH  = dotq_pkg::DEF_TIME_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cmd_valid,
    input  dotq_pkg::t_cmd                     i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dotq_pkg::M_DATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned PTR_W = IDX_W + 1;
    localparam logic [PTR_W-1:0] NIL = '1;
    localparam int unsigned NF_W = $clog2(dotq_pkg::MAX_FIRE + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INS_START = 4'd1;
    localparam logic [3:0] S_INS_CHK   = 4'd2;
    localparam logic [3:0] S_INS_CMP   = 4'd3;
    localparam logic [3:0] S_INS_FREE  = 4'd4;
    localparam logic [3:0] S_INS_POP   = 4'd5;
    localparam logic [3:0] S_INS_LNK   = 4'd6;
    localparam logic [3:0] S_REM_CHK   = 4'd7;
    localparam logic [3:0] S_REM_CMP   = 4'd8;
    localparam logic [3:0] S_REM_LNK   = 4'd9;
    localparam logic [3:0] S_FIRE_CHK  = 4'd10;
    localparam logic [3:0] S_FIRE_CMP  = 4'd11;
    localparam logic [3:0] S_EMIT      = 4'd12;

    // Entry memories
    logic [31:0]           m_tag  [TABLE_DEPTH];
    logic [31:0]           m_per  [TABLE_DEPTH];
    logic [TIME_WIDTH-1:0] m_dl   [TABLE_DEPTH];
    logic [PTR_W-1:0]      m_lnk  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_lv;

    logic [31:0]           r_tag_q;
    logic [31:0]           r_per_q;
    logic [TIME_WIDTH-1:0] r_dl_q;
    logic [PTR_W-1:0]      r_lnk_q;
    logic                  r_lv_q;
    logic [IDX_W-1:0]      r_ra_q;
    logic [PTR_W-1:0]      s_link;

    // Control state
    logic [3:0]            r_st, n_st;
    logic [2:0]            r_op;
    logic [PTR_W-1:0]      r_used, n_used;
    logic [PTR_W-1:0]      r_free, n_free;
    logic [PTR_W-1:0]      r_cur, n_cur;
    logic [PTR_W-1:0]      r_prev, n_prev;
    logic [PTR_W-1:0]      r_aux, n_aux;
    logic [TIME_WIDTH-1:0] r_time, n_time;
    logic [TIME_WIDTH-1:0] r_idl, n_idl;
    logic [31:0]           r_itag, n_itag;
    logic [31:0]           r_iper, n_iper;
    logic [dotq_pkg::COUNT_W-1:0]  r_cnt, n_cnt;
    logic [dotq_pkg::STATUS_W-1:0] r_rst_code, n_rst_code;
    logic [NF_W-1:0]       r_nfire, n_nfire;
    logic                  r_pend_v, n_pend_v;
    logic [31:0]           r_pend_tag, n_pend_tag;
    logic [31:0]           r_pend_per, n_pend_per;
    logic                  r_run_v, n_run_v;
    logic [31:0]           r_run_tag, n_run_tag;
    logic [31:0]           r_run_per, n_run_per;
    logic                  n_op_load;

    // Read and write ports
    logic [IDX_W-1:0]      s_ra;
    logic                  s_ew;
    logic [IDX_W-1:0]      s_ewa;
    logic                  s_lw;
    logic [IDX_W-1:0]      s_lwa;
    logic [PTR_W-1:0]      s_lwd;

    // Output register
    logic                  r_ovld;
    logic                  s_ofree;
    logic                  n_oload;
    logic                  n_ofired;
    logic [31:0]           n_otag;
    logic [31:0]           n_oper;
    logic [dotq_pkg::COUNT_W-1:0]  n_ocnt;
    logic [dotq_pkg::STATUS_W-1:0] n_ost;
    logic                  n_olast;

    logic s_match;
    logic s_run_match;

    assign s_ofree = !r_ovld || i_m_tready;
    assign s_link  = r_lv_q ? r_lnk_q :
                     ((r_ra_q == '0) ? NIL : {1'b0, r_ra_q - IDX_W'(1)});
    assign s_match = (r_tag_q == r_itag) && (r_per_q == r_iper);
    assign s_run_match = r_run_v && (r_run_tag == r_itag) && (r_run_per == r_iper);

    always_comb begin
        n_st = r_st;  n_op_load = 1'b0;
        n_used = r_used;  n_free = r_free;  n_cur = r_cur;  n_prev = r_prev;
        n_aux = r_aux;  n_time = r_time;  n_idl = r_idl;
        n_itag = r_itag;  n_iper = r_iper;  n_cnt = r_cnt;  n_rst_code = r_rst_code;
        n_nfire = r_nfire;  n_pend_v = r_pend_v;
        n_pend_tag = r_pend_tag;  n_pend_per = r_pend_per;
        n_run_v = r_run_v;  n_run_tag = r_run_tag;  n_run_per = r_run_per;
        s_ra = r_used[IDX_W-1:0];
        s_ew = 1'b0;  s_ewa = r_free[IDX_W-1:0];
        s_lw = 1'b0;  s_lwa = r_cur[IDX_W-1:0];  s_lwd = r_cur;
        n_oload = 1'b0;  n_ofired = 1'b0;  n_otag = '0;  n_oper = '0;
        n_ocnt = '0;  n_ost = dotq_pkg::ST_OK;  n_olast = 1'b1;
        o_cmd_pop = 1'b0;

        case (r_st)
            // Take the next command and dispatch it
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop  = 1'b1;
                    n_op_load  = 1'b1;
                    n_itag     = i_cmd.tag;
                    n_iper     = i_cmd.per;
                    n_cnt      = '0;
                    n_rst_code = dotq_pkg::ST_OK;
                    n_nfire    = '0;
                    n_prev     = NIL;
                    n_cur      = r_used;
                    case (i_cmd.op)
                        dotq_pkg::OP_ADD: begin
                            n_idl = r_time + TIME_WIDTH'(i_cmd.dly);
                            n_st  = S_INS_START;
                        end
                        dotq_pkg::OP_DEL, dotq_pkg::OP_ADV: n_st = S_REM_CHK;
                        dotq_pkg::OP_TICK: begin
                            n_time = r_time + TIME_WIDTH'(1);
                            n_st   = S_FIRE_CHK;
                        end
                        dotq_pkg::OP_DONE: begin
                            n_run_v = 1'b0;
                            n_st    = S_EMIT;
                        end
                        default: n_st = S_EMIT;
                    endcase
                end
            end
            // Insert: check for a free slot
            S_INS_START: begin
                if (r_free == NIL) begin
                    n_rst_code = dotq_pkg::ST_FULL;
                    n_st = S_EMIT;
                end else begin
                    n_prev = NIL;
                    n_cur  = r_used;
                    n_st   = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                s_ra = r_cur[IDX_W-1:0];
                n_st = (r_cur == NIL) ? S_INS_FREE : S_INS_CMP;
            end
            // Advance past entries with an earlier deadline
            S_INS_CMP: begin
                if (r_idl > r_dl_q) begin
                    n_prev = r_cur;
                    n_cur  = s_link;
                    n_st   = S_INS_CHK;
                end else begin
                    n_st = S_INS_FREE;
                end
            end
            S_INS_FREE: begin
                s_ra = r_free[IDX_W-1:0];
                n_st = S_INS_POP;
            end
            // Pop the free slot and fill it
            S_INS_POP: begin
                n_aux  = r_free;
                n_free = s_link;
                s_ew   = 1'b1;
                s_ewa  = r_free[IDX_W-1:0];
                s_lw   = 1'b1;
                s_lwa  = r_free[IDX_W-1:0];
                s_lwd  = r_cur;
                if (r_prev != NIL) begin
                    n_st = S_INS_LNK;
                end else begin
                    n_used = r_free;
                    n_st   = (r_op == dotq_pkg::OP_TICK) ? S_FIRE_CHK : S_EMIT;
                end
            end
            S_INS_LNK: begin
                s_lw  = 1'b1;
                s_lwa = r_prev[IDX_W-1:0];
                s_lwd = r_aux;
                n_st  = (r_op == dotq_pkg::OP_TICK) ? S_FIRE_CHK : S_EMIT;
            end
            // Remove: walk the list
            S_REM_CHK: begin
                s_ra = r_cur[IDX_W-1:0];
                if (r_cur != NIL) begin
                    n_st = S_REM_CMP;
                end else if (r_op == dotq_pkg::OP_ADV) begin
                    if (r_cnt == '0 && s_run_match) begin
                        n_rst_code = dotq_pkg::ST_RUNNING;
                        n_st = S_EMIT;
                    end else begin
                        n_idl = r_time;
                        n_st  = S_INS_START;
                    end
                end else begin
                    n_st = S_EMIT;
                end
            end
            S_REM_CMP: begin
                if (s_match) begin
                    s_lw   = 1'b1;
                    s_lwa  = r_cur[IDX_W-1:0];
                    s_lwd  = r_free;
                    n_free = r_cur;
                    if (r_cnt != '1) begin
                        n_cnt = r_cnt + dotq_pkg::COUNT_W'(1);
                    end
                    n_aux = s_link;
                    n_cur = s_link;
                    if (r_prev != NIL) begin
                        n_st = S_REM_LNK;
                    end else begin
                        n_used = s_link;
                        n_st   = S_REM_CHK;
                    end
                end else begin
                    n_prev = r_cur;
                    n_cur  = s_link;
                    n_st   = S_REM_CHK;
                end
            end
            // Unlink the removed entry from its predecessor
            S_REM_LNK: begin
                s_lw  = 1'b1;
                s_lwa = r_prev[IDX_W-1:0];
                s_lwd = r_aux;
                s_ra  = r_aux[IDX_W-1:0];
                n_st  = S_REM_CHK;
            end
            // Fire: look at the head entry
            S_FIRE_CHK: begin
                s_ra = r_used[IDX_W-1:0];
                if (r_nfire == NF_W'(dotq_pkg::MAX_FIRE) || r_used == NIL) begin
                    n_st = S_EMIT;
                end else begin
                    n_st = S_FIRE_CMP;
                end
            end
            S_FIRE_CMP: begin
                s_ra = r_used[IDX_W-1:0];
                if (r_dl_q > r_time) begin
                    n_st = S_EMIT;
                end else if (!r_pend_v || s_ofree) begin
                    // Send the previous fired job, not the last one
                    if (r_pend_v) begin
                        n_oload  = 1'b1;
                        n_ofired = 1'b1;
                        n_otag   = r_pend_tag;
                        n_oper   = r_pend_per;
                        n_olast  = 1'b0;
                    end
                    n_pend_v   = 1'b1;
                    n_pend_tag = r_tag_q;
                    n_pend_per = r_per_q;
                    n_run_v    = 1'b1;
                    n_run_tag  = r_tag_q;
                    n_run_per  = r_per_q;
                    n_nfire    = r_nfire + NF_W'(1);
                    n_used     = s_link;
                    s_lw       = 1'b1;
                    s_lwa      = r_used[IDX_W-1:0];
                    s_lwd      = r_free;
                    n_free     = r_used;
                    if (r_per_q != '0) begin
                        n_itag = r_tag_q;
                        n_iper = r_per_q;
                        n_idl  = r_time + TIME_WIDTH'(r_per_q);
                        n_st   = S_INS_START;
                    end else begin
                        n_st = S_FIRE_CHK;
                    end
                end
            end
            // Deliver the final result word
            S_EMIT: begin
                if (s_ofree) begin
                    n_oload  = 1'b1;
                    n_ofired = r_pend_v;
                    n_otag   = r_pend_v ? r_pend_tag : '0;
                    n_oper   = r_pend_v ? r_pend_per : '0;
                    n_ocnt   = r_cnt;
                    n_ost    = r_rst_code;
                    n_olast  = 1'b1;
                    n_pend_v = 1'b0;
                    n_st     = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_used   <= NIL;
            r_free   <= PTR_W'(TABLE_DEPTH - 1);
            r_time   <= '0;
            r_run_v  <= 1'b0;
            r_run_tag <= '0;
            r_run_per <= '0;
            r_pend_v <= 1'b0;
            r_nfire  <= '0;
            r_lv     <= '0;
            r_ovld   <= 1'b0;
            r_op     <= dotq_pkg::OP_NOP;
        end else begin
            r_st      <= n_st;
            r_used    <= n_used;
            r_free    <= n_free;
            r_time    <= n_time;
            r_run_v   <= n_run_v;
            r_run_tag <= n_run_tag;
            r_run_per <= n_run_per;
            r_pend_v  <= n_pend_v;
            r_nfire   <= n_nfire;
            if (n_op_load) begin
                r_op <= i_cmd.op;
            end
            if (s_lw) begin
                r_lv[s_lwa] <= 1'b1;
            end
            if (n_oload) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // Hold walk and result payload
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_prev     <= n_prev;
        r_aux      <= n_aux;
        r_idl      <= n_idl;
        r_itag     <= n_itag;
        r_iper     <= n_iper;
        r_cnt      <= n_cnt;
        r_rst_code <= n_rst_code;
        r_pend_tag <= n_pend_tag;
        r_pend_per <= n_pend_per;
        if (n_oload) begin
            o_m_tuser <= n_ofired;
            o_m_tlast <= n_olast;
            o_m_tdata <= {1'b0, n_ost, n_ocnt, n_oper, n_otag};
        end
    end

    // Entry memories with registered read
    always_ff @(posedge i_clk) begin
        if (s_ew) begin
            m_tag[s_ewa] <= r_itag;
            m_per[s_ewa] <= r_iper;
            m_dl[s_ewa]  <= r_idl;
        end
        if (s_lw) begin
            m_lnk[s_lwa] <= s_lwd;
        end
        r_tag_q <= m_tag[s_ra];
        r_per_q <= m_per[s_ra];
        r_dl_q  <= m_dl[s_ra];
        r_lnk_q <= m_lnk[s_ra];
        r_lv_q  <= r_lv[s_ra];
        r_ra_q  <= s_ra;
    end

    assign o_m_tvalid = r_ovld;

    // Every slot is on exactly one list, so both lists cannot be empty
    a_heads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_used == NIL && r_free == NIL))
        else $error("used and free lists both empty");

    // A tick never fires more than the per-tick limit
    a_nfire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nfire <= NF_W'(dotq_pkg::MAX_FIRE))
        else $error("fire count over limit");

    // No fired job is left pending once back in idle
    a_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> !r_pend_v)
        else $error("pending fired job in idle");

    // A result is never loaded over a stalled one
    a_oload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_m_tready) |=> $stable(o_m_tdata))
        else $error("output overwritten while stalled");

endmodule

// ----- rtl/core/deadline_ordered_timer_queue.sv -----
// Top level of the deadline-ordered timer queue: front end, command queue and list engine.
//
// Input channel (s): one word per command; tuser holds the function (add, delete,
// advance, tick, running job done), tdata holds job tag, delay and repeat period.
// Output channel (m): result words; tuser flags a fired job, tlast marks the final
// word of a command. Every command gives one word; a tick that fires gives one word
// per fired job. Commands go into a two-entry queue, so the input keeps taking
// words while the engine works or the output stalls, until the queue is full.
// Sequencing: the engine handles one command at a time, taken when it leaves the queue;
// each list step reads the entry memory. Add walks the list to its place (or stops at
// once when the table is full), delete walks the whole list, advance is a delete plus
// an add; done and unknown functions walk no list. A tick walks the fired jobs, at
// most 16, plus an insert walk per periodic job.
// Reset: synchronous, active low; empties the list, puts every slot on the free list,
// clears time and the running job. No sweep is needed after reset.
// Stall: when the output is not taken the engine holds and the queue fills, then
// the input deasserts tready.
module deadline_ordered_timer_queue #(
    parameter int unsigned TABLE_DEPTH = dotq_pkg::DEF_TABLE_DEPTH,
    parameter int unsigned TIME_WIDTH  = dotq_pkg::DEF_TIME_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [31:0] job_tag, [63:32] delay, [95:64] repeat_period
    input  logic [dotq_pkg::S_DATA_W-1:0]      i_s_tdata,
    // [2:0] func
    input  logic [dotq_pkg::FUNC_W-1:0]        i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [31:0] fired_tag, [63:32] fired_period, [68:64] removed_count, [70:69] status
    output logic [dotq_pkg::M_DATA_W-1:0]      o_m_tdata,
    // [0] fired
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);

    logic           s_cmd_valid;
    logic           s_cmd_pop;
    dotq_pkg::t_cmd s_cmd;

    dotq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd_valid (s_cmd_valid),
        .o_cmd       (s_cmd),
        .i_cmd_pop   (s_cmd_pop)
    );

    dotq_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_cmd_valid),
        .i_cmd       (s_cmd),
        .o_cmd_pop   (s_cmd_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
